FILE: rtl/tdpu_pkg.sv
// Shared types, constants and decode helpers for the Thumb data-processing unit.
package tdpu_pkg;

  localparam int unsigned InstrW   = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned OutDataW = 40;

  // Opcode prefixes of the four handled formats
  localparam logic [4:0] Fmt2Prefix = 5'b00011;
  localparam logic [2:0] Fmt1Prefix = 3'b000;
  localparam logic [2:0] Fmt3Prefix = 3'b001;
  localparam logic [5:0] Fmt4Prefix = 6'b010000;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } tdpu_shift_e;

  typedef enum logic [1:0] {
    IMM_MOV = 2'd0,
    IMM_CMP = 2'd1,
    IMM_ADD = 2'd2,
    IMM_SUB = 2'd3
  } tdpu_imm_op_e;

  typedef enum logic [3:0] {
    ALU_AND = 4'h0,
    ALU_EOR = 4'h1,
    ALU_LSL = 4'h2,
    ALU_LSR = 4'h3,
    ALU_ASR = 4'h4,
    ALU_ADC = 4'h5,
    ALU_SBC = 4'h6,
    ALU_ROR = 4'h7,
    ALU_TST = 4'h8,
    ALU_NEG = 4'h9,
    ALU_CMP = 4'hA,
    ALU_CMN = 4'hB,
    ALU_ORR = 4'hC,
    ALU_MUL = 4'hD,
    ALU_BIC = 4'hE,
    ALU_MVN = 4'hF
  } tdpu_alu_op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } tdpu_flags_t;

  typedef struct packed {
    logic               handled;
    logic               reg_written;
    logic [RegIdxW-1:0] dest_index;
    logic [DataW-1:0]   dest_value;
    tdpu_flags_t        flags;
  } tdpu_result_t;

  typedef struct packed {
    logic               re;
    logic [RegIdxW-1:0] idx_a;
    logic [RegIdxW-1:0] idx_b;
  } tdpu_rd_req_t;

  typedef struct packed {
    logic               we;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } tdpu_wr_req_t;

  // First register operand: Rs for formats 1 and 2, Rd for formats 3 and 4
  function automatic logic [RegIdxW-1:0] operand_a_idx(logic [InstrW-1:0] instr);
    logic [RegIdxW-1:0] idx;
    begin
      if (instr[15:11] == Fmt2Prefix || instr[15:13] == Fmt1Prefix) begin
        idx = instr[5:3];
      end else if (instr[15:13] == Fmt3Prefix) begin
        idx = instr[10:8];
      end else begin
        idx = instr[2:0];
      end
      return idx;
    end
  endfunction

  // Second register operand: Rn for format 2, Rs for format 4
  function automatic logic [RegIdxW-1:0] operand_b_idx(logic [InstrW-1:0] instr);
    logic [RegIdxW-1:0] idx;
    begin
      if (instr[15:11] == Fmt2Prefix) begin
        idx = instr[8:6];
      end else begin
        idx = instr[5:3];
      end
      return idx;
    end
  endfunction

endpackage

FILE: rtl/tdpu_state.sv
// Low register file r0-r7 with bypassed registered reads, and the NZCV flag register.
module tdpu_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdpu_pkg::tdpu_rd_req_t        rd_req_i,
  input  tdpu_pkg::tdpu_wr_req_t        wr_req_i,
  input  logic                          flags_we_i,
  input  tdpu_pkg::tdpu_flags_t         flags_d_i,
  output logic [tdpu_pkg::DataW-1:0]    rdata_a_o,
  output logic [tdpu_pkg::DataW-1:0]    rdata_b_o,
  output tdpu_pkg::tdpu_flags_t         flags_o
);

  logic [tdpu_pkg::DataW-1:0]    regs_mem [tdpu_pkg::RegCount];
  logic [tdpu_pkg::RegCount-1:0] valid_q;
  logic [tdpu_pkg::DataW-1:0]    rdata_a_q;
  logic [tdpu_pkg::DataW-1:0]    rdata_b_q;
  tdpu_pkg::tdpu_flags_t         flags_q;

  always_ff @(posedge clk_i) begin
    if (wr_req_i.we) begin
      regs_mem[wr_req_i.idx] <= wr_req_i.data;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_req_i.we) begin
      valid_q[wr_req_i.idx] <= 1'b1;
    end
  end

  // Forward a same-cycle write so the next item sees it
  always_ff @(posedge clk_i) begin
    if (rd_req_i.re) begin
      if (wr_req_i.we && wr_req_i.idx == rd_req_i.idx_a) begin
        rdata_a_q <= wr_req_i.data;
      end else if (valid_q[rd_req_i.idx_a]) begin
        rdata_a_q <= regs_mem[rd_req_i.idx_a];
      end else begin
        rdata_a_q <= '0;
      end
      if (wr_req_i.we && wr_req_i.idx == rd_req_i.idx_b) begin
        rdata_b_q <= wr_req_i.data;
      end else if (valid_q[rd_req_i.idx_b]) begin
        rdata_b_q <= regs_mem[rd_req_i.idx_b];
      end else begin
        rdata_b_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (flags_we_i) begin
      flags_q <= flags_d_i;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;
  assign flags_o   = flags_q;

endmodule

FILE: rtl/tdpu_alu.sv
// Decode and execute of Thumb formats 1 to 4: shifter, adder, logic ops and multiplier.
module tdpu_alu (
  input  logic [tdpu_pkg::InstrW-1:0] instr_i,
  input  logic [tdpu_pkg::DataW-1:0]  op_a_i,
  input  logic [tdpu_pkg::DataW-1:0]  op_b_i,
  input  tdpu_pkg::tdpu_flags_t       flags_i,
  output tdpu_pkg::tdpu_result_t      result_o
);

  // Returns {carry, value}; carry in passes when the amount is zero
  function automatic logic [tdpu_pkg::DataW:0] shift_op(tdpu_pkg::tdpu_shift_e kind,
                                                        logic [tdpu_pkg::DataW-1:0] v,
                                                        logic [7:0] amt, logic cin);
    logic [tdpu_pkg::DataW:0]     wide;
    logic [2*tdpu_pkg::DataW-1:0] rot;
    logic [tdpu_pkg::DataW:0]     res;
    begin
      wide = '0;
      rot  = '0;
      res  = {cin, v};
      if (amt != 8'd0) begin
        case (kind)
          tdpu_pkg::SHIFT_LSL: begin
            if (amt < 8'd32) begin
              wide = {1'b0, v} << amt[4:0];
              res  = wide;
            end else if (amt == 8'd32) begin
              res = {v[0], 32'd0};
            end else begin
              res = '0;
            end
          end
          tdpu_pkg::SHIFT_LSR: begin
            if (amt < 8'd32) begin
              wide = {v, 1'b0} >> amt[4:0];
              res  = {wide[0], wide[32:1]};
            end else if (amt == 8'd32) begin
              res = {v[31], 32'd0};
            end else begin
              res = '0;
            end
          end
          tdpu_pkg::SHIFT_ASR: begin
            if (amt < 8'd32) begin
              wide = $signed({v, 1'b0}) >>> amt[4:0];
              res  = {wide[0], wide[32:1]};
            end else begin
              res = {v[31], {32{v[31]}}};
            end
          end
          tdpu_pkg::SHIFT_ROR: begin
            // A multiple of 32 keeps the value with carry from bit 31
            rot = {v, v} >> amt[4:0];
            res = {rot[31], rot[31:0]};
          end
          default: res = {cin, v};
        endcase
      end
      return res;
    end
  endfunction

  // a + b + cin with full NZCV; b is already folded for subtraction
  function automatic tdpu_pkg::tdpu_result_t add_op(logic [tdpu_pkg::DataW-1:0] a,
                                                    logic [tdpu_pkg::DataW-1:0] b,
                                                    logic cin);
    logic [tdpu_pkg::DataW:0] sum;
    tdpu_pkg::tdpu_result_t   r;
    begin
      r            = '0;
      sum          = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      r.dest_value = sum[31:0];
      r.flags.n    = sum[31];
      r.flags.z    = (sum[31:0] == '0);
      r.flags.c    = sum[32];
      r.flags.v    = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
      return r;
    end
  endfunction

  logic                       is_fmt1;
  logic                       is_fmt2;
  logic                       is_fmt3;
  logic                       is_fmt4;
  logic [tdpu_pkg::DataW-1:0] imm3;
  logic [tdpu_pkg::DataW-1:0] imm8;
  logic [tdpu_pkg::DataW-1:0] add_b;
  logic [7:0]                 amt1;
  logic [tdpu_pkg::DataW:0]   sh;
  logic [tdpu_pkg::DataW-1:0] logic_val;
  logic [tdpu_pkg::DataW-1:0] mul_val;
  tdpu_pkg::tdpu_shift_e      kind;
  tdpu_pkg::tdpu_imm_op_e     imm_op;
  tdpu_pkg::tdpu_alu_op_e     alu_op;
  tdpu_pkg::tdpu_result_t     sum_r;
  tdpu_pkg::tdpu_result_t     res;

  assign is_fmt2 = (instr_i[15:11] == tdpu_pkg::Fmt2Prefix);
  assign is_fmt1 = (instr_i[15:13] == tdpu_pkg::Fmt1Prefix) && !is_fmt2;
  assign is_fmt3 = (instr_i[15:13] == tdpu_pkg::Fmt3Prefix);
  assign is_fmt4 = (instr_i[15:10] == tdpu_pkg::Fmt4Prefix);

  assign imm3    = {29'd0, instr_i[8:6]};
  assign imm8    = {24'd0, instr_i[7:0]};
  assign mul_val = op_a_i * op_b_i;

  always_comb begin
    res        = '0;
    res.flags  = flags_i;
    kind       = tdpu_pkg::tdpu_shift_e'(instr_i[12:11]);
    imm_op     = tdpu_pkg::tdpu_imm_op_e'(instr_i[12:11]);
    alu_op     = tdpu_pkg::tdpu_alu_op_e'(instr_i[9:6]);
    add_b      = '0;
    amt1       = {3'd0, instr_i[10:6]};
    sh         = '0;
    logic_val  = '0;
    sum_r      = '0;

    if (is_fmt2) begin
      add_b = instr_i[10] ? imm3 : op_b_i;
      if (instr_i[9]) begin
        sum_r = add_op(op_a_i, ~add_b, 1'b1);
      end else begin
        sum_r = add_op(op_a_i, add_b, 1'b0);
      end
      res.dest_value = sum_r.dest_value;
      res.flags      = sum_r.flags;
      res.dest_index = instr_i[2:0];
      res.handled    = 1'b1;
      res.reg_written = 1'b1;
    end else if (is_fmt1) begin
      // LSR and ASR by zero encode a shift by 32
      if (instr_i[10:6] == 5'd0 && kind != tdpu_pkg::SHIFT_LSL) begin
        amt1 = 8'd32;
      end
      sh             = shift_op(kind, op_a_i, amt1, flags_i.c);
      res.dest_value = sh[31:0];
      res.flags.n    = sh[31];
      res.flags.z    = (sh[31:0] == '0);
      res.flags.c    = sh[32];
      res.dest_index = instr_i[2:0];
      res.handled    = 1'b1;
      res.reg_written = 1'b1;
    end else if (is_fmt3) begin
      res.dest_index  = instr_i[10:8];
      res.handled     = 1'b1;
      res.reg_written = (imm_op != tdpu_pkg::IMM_CMP);
      case (imm_op)
        tdpu_pkg::IMM_MOV: begin
          res.dest_value = imm8;
          res.flags.n    = 1'b0;
          res.flags.z    = (imm8 == '0);
        end
        tdpu_pkg::IMM_ADD: begin
          sum_r          = add_op(op_a_i, imm8, 1'b0);
          res.dest_value = sum_r.dest_value;
          res.flags      = sum_r.flags;
        end
        default: begin
          sum_r          = add_op(op_a_i, ~imm8, 1'b1);
          res.dest_value = sum_r.dest_value;
          res.flags      = sum_r.flags;
        end
      endcase
    end else if (is_fmt4) begin
      res.dest_index  = instr_i[2:0];
      res.handled     = 1'b1;
      res.reg_written = 1'b1;
      case (alu_op)
        tdpu_pkg::ALU_AND, tdpu_pkg::ALU_TST: logic_val = op_a_i & op_b_i;
        tdpu_pkg::ALU_EOR: logic_val = op_a_i ^ op_b_i;
        tdpu_pkg::ALU_ORR: logic_val = op_a_i | op_b_i;
        tdpu_pkg::ALU_MUL: logic_val = mul_val;
        tdpu_pkg::ALU_BIC: logic_val = op_a_i & ~op_b_i;
        tdpu_pkg::ALU_MVN: logic_val = ~op_b_i;
        default:           logic_val = '0;
      endcase
      case (alu_op)
        tdpu_pkg::ALU_LSL: sh = shift_op(tdpu_pkg::SHIFT_LSL, op_a_i, op_b_i[7:0], flags_i.c);
        tdpu_pkg::ALU_LSR: sh = shift_op(tdpu_pkg::SHIFT_LSR, op_a_i, op_b_i[7:0], flags_i.c);
        tdpu_pkg::ALU_ASR: sh = shift_op(tdpu_pkg::SHIFT_ASR, op_a_i, op_b_i[7:0], flags_i.c);
        default:           sh = shift_op(tdpu_pkg::SHIFT_ROR, op_a_i, op_b_i[7:0], flags_i.c);
      endcase
      case (alu_op)
        tdpu_pkg::ALU_ADC: sum_r = add_op(op_a_i, op_b_i, flags_i.c);
        tdpu_pkg::ALU_SBC: sum_r = add_op(op_a_i, ~op_b_i, flags_i.c);
        tdpu_pkg::ALU_NEG: sum_r = add_op('0, ~op_b_i, 1'b1);
        tdpu_pkg::ALU_CMP: sum_r = add_op(op_a_i, ~op_b_i, 1'b1);
        default:           sum_r = add_op(op_a_i, op_b_i, 1'b0);
      endcase
      case (alu_op)
        tdpu_pkg::ALU_LSL, tdpu_pkg::ALU_LSR, tdpu_pkg::ALU_ASR, tdpu_pkg::ALU_ROR: begin
          res.dest_value = sh[31:0];
          res.flags.n    = sh[31];
          res.flags.z    = (sh[31:0] == '0);
          res.flags.c    = sh[32];
        end
        tdpu_pkg::ALU_ADC, tdpu_pkg::ALU_SBC, tdpu_pkg::ALU_NEG,
        tdpu_pkg::ALU_CMP, tdpu_pkg::ALU_CMN: begin
          res.dest_value = sum_r.dest_value;
          res.flags      = sum_r.flags;
        end
        default: begin
          res.dest_value = logic_val;
          res.flags.n    = logic_val[31];
          res.flags.z    = (logic_val == '0);
        end
      endcase
      if (alu_op inside {tdpu_pkg::ALU_TST, tdpu_pkg::ALU_CMP, tdpu_pkg::ALU_CMN}) begin
        res.reg_written = 1'b0;
      end
    end
  end

  assign result_o = res;

endmodule

FILE: rtl/thumb_data_processing_unit_top.sv
// Path: operand read registers, then execute into the output register. Throughput: one
// instruction per cycle unless the output stalls; execute reads r0-r7 and NZCV as left
// by the previous instruction, through a write bypass on the operand read.
// Output register decouples the sides; the input stage stalls only while it is full.
// Reset: asynchronous, active low; clears r0-r7 (via valid bits), the flags and all
// valid state.
module thumb_data_processing_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] instr
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [0] reg_written, [3:1] dest_index,
                                        // [35:4] dest_value, [36] flag_n, [37] flag_z,
                                        // [38] flag_c, [39] flag_v
  output logic        m_axis_tuser_o    // [0] handled
);

  logic                          in_valid_q;
  logic [tdpu_pkg::InstrW-1:0]   instr_q;
  logic                          out_valid_q;
  tdpu_pkg::tdpu_result_t        result_q;
  logic                          exec_fire;
  logic                          in_accept;
  logic [tdpu_pkg::DataW-1:0]    op_a;
  logic [tdpu_pkg::DataW-1:0]    op_b;
  tdpu_pkg::tdpu_flags_t         flags;
  tdpu_pkg::tdpu_result_t        result;
  tdpu_pkg::tdpu_rd_req_t        rd_req;
  tdpu_pkg::tdpu_wr_req_t        wr_req;

  assign exec_fire       = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || exec_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_req.re    = in_accept;
  assign rd_req.idx_a = tdpu_pkg::operand_a_idx(s_axis_tdata_i);
  assign rd_req.idx_b = tdpu_pkg::operand_b_idx(s_axis_tdata_i);

  assign wr_req.we   = exec_fire && result.reg_written;
  assign wr_req.idx  = result.dest_index;
  assign wr_req.data = result.dest_value;

  tdpu_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_req_i   (rd_req),
    .wr_req_i   (wr_req),
    .flags_we_i (exec_fire),
    .flags_d_i  (result.flags),
    .rdata_a_o  (op_a),
    .rdata_b_o  (op_b),
    .flags_o    (flags)
  );

  tdpu_alu u_alu (
    .instr_i  (instr_q),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .flags_i  (flags),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (exec_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = result_q.handled;
  assign m_axis_tdata_o  = {result_q.flags.v, result_q.flags.c, result_q.flags.z,
                            result_q.flags.n, result_q.dest_value, result_q.dest_index,
                            result_q.reg_written};

`ifndef SYNTH
  // An unhandled halfword writes nothing and reports zero index and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[35:0] == '0))
    else $error("unhandled result carries a write or a value");

  // An executed instruction always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> m_axis_tvalid_o)
    else $error("executed instruction lost before the output");

  // A stalled instruction holds in the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec_fire) |=> (in_valid_q && $stable(instr_q)))
    else $error("stalled instruction dropped or changed");
`endif

endmodule
